// ----- sv/mcp_pkg.sv -----
// mcp_pkg: shared types and constants of the motor command text parser
// holds the action and reply codes, character codes and the stage word type
// no dependencies
package mcp_pkg;

  // field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned STATUS_W  = 4;
  localparam int unsigned STEP_W    = 4;
  localparam int unsigned HALL_W    = 3;
  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned REPLY_W   = 2;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned ARG_W     = 10;
  localparam int unsigned PRODUCT_W = PERIOD_W + ARG_W;

  // reset value of the timer period
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);

  // duty argument limits
  localparam logic [ARG_W-1:0] ARG_LIMIT     = ARG_W'(1000);
  localparam logic [ARG_W-1:0] ARG_SATURATED = ARG_W'(1001);

  // divide by 1000: shift by 3, then multiply by ceil(2^30 / 125)
  localparam int unsigned DIV_PRE_SHIFT = 3;
  localparam int unsigned DIV_SHIFT     = 30;
  localparam int unsigned RECIP_W       = 24;
  localparam logic [RECIP_W-1:0] RECIP_125 = RECIP_W'(8589935);

  // action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_OFF        = 3'd0,
    ACT_ON         = 3'd1,
    ACT_CW         = 3'd2,
    ACT_CCW        = 3'd3,
    ACT_RUN_DUTY   = 3'd4,
    ACT_START_DUTY = 3'd5,
    ACT_STATUS     = 3'd6
  } action_t;

  // reply codes
  typedef enum logic [REPLY_W-1:0] {
    REPLY_ACK    = 2'd0,
    REPLY_NAK    = 2'd1,
    REPLY_STATUS = 2'd2
  } reply_t;

  // character codes
  localparam logic [BYTE_W-1:0] CH_M     = 8'h6D;
  localparam logic [BYTE_W-1:0] CH_D     = 8'h64;
  localparam logic [BYTE_W-1:0] CH_R     = 8'h72;
  localparam logic [BYTE_W-1:0] CH_S     = 8'h73;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_ONE   = 8'h31;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  // word between the parser stage and the scaling stage
  typedef struct packed {
    action_t                action;
    reply_t                 reply_kind;
    logic [PRODUCT_W-1:0]   product;
    logic [STATUS_W-1:0]    status_value;
    logic [STEP_W-1:0]      step_value;
    logic [HALL_W-1:0]      hall_bits;
  } stage_t;

endpackage

// ----- sv/mcp_if.sv -----
// mcp_if: valid/ready channels of the motor command text parser
// input channel carries one command byte plus motor status, result channel one reply
// depends on mcp_pkg
interface mcp_in_if;
  logic                            valid;
  logic                            ready;
  logic [mcp_pkg::BYTE_W-1:0]      rx_byte;
  logic [mcp_pkg::STATUS_W-1:0]    motor_status;
  logic [mcp_pkg::STEP_W-1:0]      comm_step;
  logic [mcp_pkg::HALL_W-1:0]      hall_state;

  modport source (output valid, rx_byte, motor_status, comm_step, hall_state,
                  input ready);
  modport sink (input valid, rx_byte, motor_status, comm_step, hall_state,
                output ready);
endinterface

interface mcp_out_if;
  logic                            valid;
  logic                            ready;
  logic [mcp_pkg::ACTION_W-1:0]    action;
  logic [mcp_pkg::REPLY_W-1:0]     reply_kind;
  logic [mcp_pkg::PERIOD_W-1:0]    pulse_width;
  logic [mcp_pkg::STATUS_W-1:0]    status_value;
  logic [mcp_pkg::STEP_W-1:0]      step_value;
  logic [mcp_pkg::HALL_W-1:0]      hall_bits;

  modport source (output valid, action, reply_kind, pulse_width, status_value,
                  step_value, hall_bits, input ready);
  modport sink (input valid, action, reply_kind, pulse_width, status_value,
                step_value, hall_bits, output ready);
endinterface

// ----- sv/mcp_parser.sv -----
// mcp_parser: command state machine, period register and first pipeline stage
// decodes one byte per cycle while in_ch.ready is high and registers the reply with period*argument
// depends on mcp_pkg and mcp_in_if
module mcp_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mcp_pkg::PERIOD_W-1:0]   cfg_wdata,
  mcp_in_if.sink                         in_ch,
  input  logic                           s2_ready,
  output logic                           s1_valid,
  output mcp_pkg::stage_t                s1_word
);
  import mcp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_M         = 4'd1,
    ST_M_COLON   = 4'd2,
    ST_D         = 4'd3,
    ST_D_COLON   = 4'd4,
    ST_R         = 4'd5,
    ST_R_COLON   = 4'd6,
    ST_S         = 4'd7,
    ST_S_D       = 4'd8,
    ST_S_D_COLON = 4'd9,
    ST_ARG       = 4'd10,
    ST_READY     = 4'd11
  } state_t;

  state_t                state_r, state_nxt;
  action_t               pend_r, pend_nxt;
  logic [ARG_W-1:0]      acc_r, acc_nxt;
  logic [PERIOD_W-1:0]   period_r;
  logic                  s1_valid_r;
  stage_t                s1_word_r, s1_word_nxt;

  logic [BYTE_W-1:0]     c;
  logic                  is_digit, is_term, exec, accept;
  logic [3:0]            digit_val;
  logic [13:0]           acc_grow;
  logic                  is_duty, is_nak;

  // byte classification; a digit's value is its low nibble
  assign c         = in_ch.rx_byte;
  assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_term   = (c == CH_LF) || (c == CH_CR);
  assign digit_val = c[3:0];
  assign acc_grow  = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + {10'd0, digit_val};

  // next state of the command parser
  always_comb begin
    state_nxt = ST_IDLE;
    pend_nxt  = pend_r;
    acc_nxt   = acc_r;
    exec      = 1'b0;
    unique case (state_r)
      ST_M: begin
        if (c == CH_COLON) state_nxt = ST_M_COLON;
      end
      ST_M_COLON: begin
        if (c == CH_ZERO) begin
          pend_nxt  = ACT_OFF;
          state_nxt = ST_READY;
        end else if (c == CH_ONE) begin
          pend_nxt  = ACT_ON;
          state_nxt = ST_READY;
        end
      end
      ST_D: begin
        if (c == CH_COLON) state_nxt = ST_D_COLON;
      end
      ST_R: begin
        if (c == CH_COLON) state_nxt = ST_R_COLON;
      end
      ST_R_COLON: begin
        if (c == CH_PLUS) begin
          pend_nxt  = ACT_CW;
          state_nxt = ST_READY;
        end else if (c == CH_MINUS) begin
          pend_nxt  = ACT_CCW;
          state_nxt = ST_READY;
        end
      end
      ST_S: begin
        if (c == CH_D) begin
          state_nxt = ST_S_D;
        end else if (c == CH_R) begin
          pend_nxt  = ACT_STATUS;
          state_nxt = ST_READY;
        end
      end
      ST_S_D: begin
        if (c == CH_COLON) state_nxt = ST_S_D_COLON;
      end
      ST_D_COLON, ST_S_D_COLON: begin
        if (is_digit) begin
          pend_nxt  = (state_r == ST_D_COLON) ? ACT_RUN_DUTY : ACT_START_DUTY;
          acc_nxt   = {6'd0, digit_val};
          state_nxt = ST_ARG;
        end
      end
      ST_ARG: begin
        if (is_term) begin
          exec = 1'b1;
        end else if (is_digit) begin
          acc_nxt   = (acc_grow > {4'd0, ARG_SATURATED}) ? ARG_SATURATED : acc_grow[ARG_W-1:0];
          state_nxt = ST_ARG;
        end
      end
      ST_READY: begin
        if (is_term) exec = 1'b1;
      end
      default: begin
        // idle and unused codes
        if (c == CH_M)      state_nxt = ST_M;
        else if (c == CH_D) state_nxt = ST_D;
        else if (c == CH_R) state_nxt = ST_R;
        else if (c == CH_S) state_nxt = ST_S;
      end
    endcase
  end

  // reply word for the pending command
  assign is_duty = (pend_r == ACT_RUN_DUTY) || (pend_r == ACT_START_DUTY);
  assign is_nak  = is_duty && (acc_r > ARG_LIMIT);

  always_comb begin
    s1_word_nxt              = '0;
    s1_word_nxt.action       = pend_r;
    s1_word_nxt.reply_kind   = REPLY_ACK;
    if (pend_r == ACT_STATUS) begin
      s1_word_nxt.reply_kind   = REPLY_STATUS;
      s1_word_nxt.status_value = in_ch.motor_status;
      s1_word_nxt.step_value   = in_ch.comm_step;
      s1_word_nxt.hall_bits    = in_ch.hall_state;
    end else if (is_nak) begin
      s1_word_nxt.reply_kind   = REPLY_NAK;
    end else if (is_duty) begin
      s1_word_nxt.product      = {{ARG_W{1'b0}}, period_r} * {{PERIOD_W{1'b0}}, acc_r};
    end
  end

  // handshake: stage register frees when empty or moving on
  assign in_ch.ready = !s1_valid_r || s2_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // parser state, period register and stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pend_r     <= ACT_OFF;
      acc_r      <= '0;
      period_r   <= PERIOD_RESET;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_we) period_r <= cfg_wdata;
      if (accept) begin
        state_r <= state_nxt;
        pend_r  <= pend_nxt;
        acc_r   <= acc_nxt;
      end
      if (in_ch.ready) s1_valid_r <= accept && exec;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (accept && exec) s1_word_r <= s1_word_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1_word  = s1_word_r;

endmodule

// ----- sv/mcp_scale.sv -----
// mcp_scale: second pipeline stage, divides period*argument by 1000
// and holds the result word in the output register
// depends on mcp_pkg and mcp_out_if
module mcp_scale (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s1_valid,
  input  mcp_pkg::stage_t      s1_word,
  output logic                 s2_ready,
  mcp_out_if.source            out_ch
);
  import mcp_pkg::*;

  localparam int unsigned X_W = PRODUCT_W - DIV_PRE_SHIFT;
  localparam int unsigned M_W = X_W + RECIP_W;

  logic                   out_valid_r;
  logic [X_W-1:0]         x;
  logic [M_W-1:0]         scaled;
  logic [PERIOD_W-1:0]    quot;
  action_t                action_r;
  reply_t                 reply_r;
  logic [PERIOD_W-1:0]    pulse_r;
  logic [STATUS_W-1:0]    status_r;
  logic [STEP_W-1:0]      step_r;
  logic [HALL_W-1:0]      hall_r;

  // floor(p / 1000) = floor(floor(p / 8) * ceil(2^30 / 125) / 2^30)
  assign x      = s1_word.product[PRODUCT_W-1:DIV_PRE_SHIFT];
  assign scaled = {{RECIP_W{1'b0}}, x} * {{X_W{1'b0}}, RECIP_125};
  assign quot   = scaled[DIV_SHIFT +: PERIOD_W];

  // output register takes a word when empty or being read
  assign s2_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      action_r <= s1_word.action;
      reply_r  <= s1_word.reply_kind;
      pulse_r  <= quot;
      status_r <= s1_word.status_value;
      step_r   <= s1_word.step_value;
      hall_r   <= s1_word.hall_bits;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.action       = action_r;
  assign out_ch.reply_kind   = reply_r;
  assign out_ch.pulse_width  = pulse_r;
  assign out_ch.status_value = status_r;
  assign out_ch.step_value   = step_r;
  assign out_ch.hall_bits    = hall_r;

endmodule

// ----- sv/motor_command_text_parser.sv -----
// motor_command_text_parser: text command parser for a motor controller
// in_ch takes one received byte per word, with the motor status, the
// commutation step and the hall bits sampled alongside it. Commands are
// m:0, m:1, r:+, r:-, d:<n>, sd:<n> and sr, each ended by CR or LF; any
// unexpected byte drops back to idle without a reply.
// out_ch gives one word per executed command: action, reply kind, pulse
// value (timer_period*n/1000, truncated) or the captured status fields.
// cfg_we/cfg_wdata write the timer period; write it only while idle.
// Throughput: one byte per cycle while in_ch.ready is high. Two register stages
// lie between the edge that accepts the terminator and the reply on out_ch: the
// parser stage (state machine, period*n multiply) and the scaling stage (divide
// by 1000 as a reciprocal multiply) that ends in the output register.
// When the receiver stalls, the two stage registers fill and in_ch.ready
// falls only once both hold a reply; bytes that give no reply pass freely
// while the stage registers have room.
// Reset (rst_n, synchronous) returns the parser to idle, empties both stages
// and sets the timer period to 1000.
// depends on mcp_pkg, mcp_if, mcp_parser and mcp_scale
module motor_command_text_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mcp_pkg::PERIOD_W-1:0]  cfg_wdata,
  mcp_in_if.sink                        in_ch,
  mcp_out_if.source                     out_ch
);
  import mcp_pkg::*;

  logic     s1_valid;
  logic     s2_ready;
  stage_t   s1_word;

  // decode stage
  mcp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .s2_ready  (s2_ready),
    .s1_valid  (s1_valid),
    .s1_word   (s1_word)
  );

  // scaling stage and output register
  mcp_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_word  (s1_word),
    .s2_ready (s2_ready),
    .out_ch   (out_ch)
  );

endmodule
